### rtl/ddo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and the arctangent table of the odometry core.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int ANGLE_BITS_DEF = 16;

    // configuration register indexes and reset values
    localparam logic REG_RADIUS = 1'b0;
    localparam logic REG_OFFSET = 1'b1;
    localparam logic [15:0] RADIUS_RST = 16'd3932;
    localparam logic [15:0] OFFSET_RST = 16'd13107;

    // pi in Q20, CORDIC gain in Q1.30
    localparam logic [21:0] PI_Q20      = 22'd3294199;
    localparam logic [33:0] CORDIC_GAIN = 34'd652032874;
    localparam int          CORDIC_STEPS = 20;

    // shared multiplier operand widths
    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic [15:0] radius;
        logic [15:0] offset;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [15:0] heading;
        logic        [31:0] path_length;
    } t_pose;

    function automatic logic [29:0] cordic_atan(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### rtl/differential_drive_odometry_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// differential_drive_odometry_core
// Dead-reckoning pose update for a two-wheel differential drive.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  -------   ---------  ---------------------   --------------------------------
//  in        sink       i_in_valid/o_in_ready   i_delta_left, i_delta_right
//  out       source     o_out_valid/i_out_ready o_pos_x, o_pos_y, o_heading,
//                                               o_path_length
//  config    APB slave  psel/penable/pready     paddr, pwdata, prdata
//
//  A beat runs from one input handshake to the next through the one-bit-a-cycle
//  heading divider (ANGLE_BITS+39 steps), 20 CORDIC steps, 23 square-root steps,
//  the nine passes through the shared multiplier and the idle, setup, mapping
//  and done states.
//  The input is ready only while the sequencer is idle; a finished pose
//  moves to the output register, so the next beat may be taken meanwhile.
//  A pose that finds the output register still full holds the sequencer in
//  its done state, and the input with it, until the register drains.
//  Reset (synchronous, active low) clears the pose and loads default registers.
//
module differential_drive_odometry_core #(
    parameter int ANGLE_BITS = ddo_pkg::ANGLE_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic signed [15:0] i_delta_left,
    input  wire logic signed [15:0] i_delta_right,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_pos_x,
    output logic signed [31:0]      o_pos_y,
    output logic        [15:0]      o_heading,
    output logic        [31:0]      o_path_length,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    ddo_pkg::t_cfg  w_cfg;
    ddo_pkg::t_pose w_pose;
    ddo_pkg::t_pose r_pose;
    logic           r_out_valid;
    logic           w_idle;
    logic           w_done;
    logic           w_take;

    ddo_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ddo_core #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_start       (i_in_valid && w_idle),
        .i_delta_left  (i_delta_left),
        .i_delta_right (i_delta_right),
        .o_idle        (w_idle),
        .o_done        (w_done),
        .i_take        (w_take),
        .o_pose        (w_pose)
    );

    // hand the pose over once the output register is free or being drained
    assign w_take = w_done && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload holds until the next pose is loaded
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_pose <= w_pose;
        end
    end

    assign o_in_ready    = w_idle;
    assign o_out_valid   = r_out_valid;
    assign o_pos_x       = r_pose.pos_x;
    assign o_pos_y       = r_pose.pos_y;
    assign o_heading     = r_pose.heading;
    assign o_path_length = r_pose.path_length;

endmodule
`default_nettype wire

### rtl/ddo_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_cfg
// APB-style register file holding wheel radius and wheel centre offset.
// ----------------------------------------------------------------------------
module ddo_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    output ddo_pkg::t_cfg      o_cfg
);

    ddo_pkg::t_cfg r_cfg;
    logic          w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius <= ddo_pkg::RADIUS_RST;
            r_cfg.offset <= ddo_pkg::OFFSET_RST;
        end else if (w_wr) begin
            if (paddr[2] == ddo_pkg::REG_RADIUS) begin
                r_cfg.radius <= pwdata[15:0];
            end else begin
                r_cfg.offset <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == ddo_pkg::REG_RADIUS) begin
            prdata = {16'd0, r_cfg.radius};
        end else begin
            prdata = {16'd0, r_cfg.offset};
        end
    end

endmodule
`default_nettype wire

### rtl/ddo_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_mul
// Shared signed multiplier with registered product, loaded on enable.
// ----------------------------------------------------------------------------
module ddo_mul (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_en,
    input  wire logic signed [ddo_pkg::MUL_A_W-1:0]   i_a,
    input  wire logic signed [ddo_pkg::MUL_B_W-1:0]   i_b,
    output logic signed      [ddo_pkg::MUL_P_W-1:0]   o_p
);

    logic signed [ddo_pkg::MUL_P_W-1:0] r_p;

    assign o_p = r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

endmodule
`default_nettype wire

### rtl/ddo_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_core
// Sequencer and datapath: divider, CORDIC, products, square root, accumulators.
// ----------------------------------------------------------------------------
module ddo_core #(
    parameter int ANGLE_BITS = ddo_pkg::ANGLE_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ddo_pkg::t_cfg      i_cfg,
    input  wire logic               i_start,
    input  wire logic signed [15:0] i_delta_left,
    input  wire logic signed [15:0] i_delta_right,
    output logic                    o_idle,
    output logic                    o_done,
    input  wire logic               i_take,
    output ddo_pkg::t_pose          o_pose
);

    localparam int AB      = ANGLE_BITS;
    localparam int NUM_W   = 32 + AB + 7;
    localparam int DEN_W   = 38;
    localparam int CNT_W   = $clog2(NUM_W + 1);
    localparam int CW      = 34;
    localparam int ACC_W   = 66;
    localparam int DX_W    = 23;
    localparam int SQ_W    = 46;
    localparam int SQ_STEPS = 23;
    localparam int PW      = ddo_pkg::MUL_P_W;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< 42;

    typedef enum logic [16:0] {
        S_IDLE  = 17'b00000000000000001,
        S_MRM   = 17'b00000000000000010,
        S_MDEN  = 17'b00000000000000100,
        S_DINIT = 17'b00000000000001000,
        S_DIV   = 17'b00000000000010000,
        S_HEAD  = 17'b00000000000100000,
        S_COR   = 17'b00000000001000000,
        S_CMAP  = 17'b00000000010000000,
        S_MXL   = 17'b00000000100000000,
        S_MXH   = 17'b00000001000000000,
        S_MYL   = 17'b00000010000000000,
        S_MYH   = 17'b00000100000000000,
        S_DY    = 17'b00001000000000000,
        S_SQ1   = 17'b00010000000000000,
        S_SQ2   = 17'b00100000000000000,
        S_SQRT  = 17'b01000000000000000,
        S_DONE  = 17'b10000000000000000
    } t_state;

    t_state                   r_state;
    logic signed [16:0]       r_dd, r_ss;
    logic [NUM_W-1:0]         r_num;
    logic [DEN_W-1:0]         r_den, r_rem;
    logic [CNT_W-1:0]         r_cnt;
    logic [AB-1:0]            r_head;
    logic signed [CW-1:0]     r_x, r_y, r_z, r_c, r_s, r_pr;
    logic [1:0]               r_quad;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [DX_W-1:0]   r_dx, r_dy;
    logic [SQ_W-1:0]          r_sqn, r_res, r_bit;
    logic signed [31:0]       r_xacc, r_yacc;
    logic [31:0]              r_dist;

    logic                                mul_en;
    logic signed [ddo_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [ddo_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [PW-1:0]                w_prod;

    logic [16:0]              w_mag;
    logic [15:0]              w_bb;
    logic [DEN_W:0]           w_trial;
    logic                     w_ge;
    logic [AB-1:0]            w_hnew;
    logic [31:0]              w_u, w_usum, w_d;
    logic signed [CW-1:0]     w_xs, w_ys, w_at;
    logic signed [ACC_W-1:0]  w_pext, w_sum;
    logic [SQ_W-1:0]          w_sqt;
    logic [AB+15:0]           w_hw;
    logic [32:0]              w_dsum;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [DX_W-1:0] d);
        logic signed [33:0] n;
        n = 34'(a) + 34'(d);
        if (n > 34'sh07FFFFFFF) begin
            return 32'sh7FFFFFFF;
        end else if (n < -34'sh080000000) begin
            return 32'sh80000000;
        end
        return n[31:0];
    endfunction

    ddo_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (w_prod)
    );

    assign w_mag   = r_dd[16] ? 17'(-r_dd) : r_dd;
    assign w_bb    = (i_cfg.offset == 16'd0) ? 16'd1 : i_cfg.offset;
    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_hnew  = r_dd[16] ? (r_head - r_num[AB-1:0]) : (r_head + r_num[AB-1:0]);
    assign w_u     = {w_hnew, {(32-AB){1'b0}}};
    assign w_usum  = w_u + 32'h2000_0000;
    assign w_d     = w_u - {w_usum[31:30], 30'd0};
    assign w_xs    = r_x >>> r_cnt[4:0];
    assign w_ys    = r_y >>> r_cnt[4:0];
    assign w_at    = CW'(ddo_pkg::cordic_atan(r_cnt[4:0]));
    assign w_pext  = ACC_W'(w_prod);
    assign w_sum   = r_acc + (w_pext <<< 23) + ROUND_HALF;
    assign w_sqt   = r_res + r_bit;
    assign w_hw    = {r_head, 16'd0};
    assign w_dsum  = {1'b0, r_dist} + 33'(r_res);

    // operand selection for the shared multiplier
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (r_state)
            S_MRM: begin
                mul_a = {19'd0, i_cfg.radius};
                mul_b = {7'd0, w_mag};
            end
            S_MDEN: begin
                mul_a = {13'd0, ddo_pkg::PI_Q20};
                mul_b = {8'd0, w_bb};
            end
            S_HEAD: begin
                mul_a = {19'd0, i_cfg.radius};
                mul_b = {{7{r_ss[16]}}, r_ss};
            end
            S_MXL: begin
                mul_a = {r_pr[CW-1], r_pr};
                mul_b = {1'b0, r_c[22:0]};
            end
            S_MXH: begin
                mul_a = {r_pr[CW-1], r_pr};
                mul_b = {{13{r_c[CW-1]}}, r_c[CW-1:23]};
            end
            S_MYL: begin
                mul_a = {r_pr[CW-1], r_pr};
                mul_b = {1'b0, r_s[22:0]};
            end
            S_MYH: begin
                mul_a = {r_pr[CW-1], r_pr};
                mul_b = {{13{r_s[CW-1]}}, r_s[CW-1:23]};
            end
            S_DY: begin
                mul_a = {{12{r_dx[DX_W-1]}}, r_dx};
                mul_b = {r_dx[DX_W-1], r_dx};
            end
            S_SQ1: begin
                mul_a = {{12{r_dy[DX_W-1]}}, r_dy};
                mul_b = {r_dy[DX_W-1], r_dy};
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_xacc  <= '0;
            r_yacc  <= '0;
            r_dist  <= '0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_dd    <= 17'(i_delta_right) - 17'(i_delta_left);
                        r_ss    <= 17'(i_delta_right) + 17'(i_delta_left);
                        r_state <= S_MRM;
                    end
                end
                S_MRM: begin
                    r_state <= S_MDEN;
                end
                S_MDEN: begin
                    r_num   <= NUM_W'({w_prod[31:0], {(AB+6){1'b0}}});
                    r_state <= S_DINIT;
                end
                S_DINIT: begin
                    r_den   <= w_prod[DEN_W-1:0];
                    r_num   <= r_num + NUM_W'(w_prod[DEN_W-1:1]);
                    r_rem   <= '0;
                    r_cnt   <= CNT_W'(NUM_W);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // one quotient bit a cycle, quotient shifts into the numerator
                    r_rem <= w_ge ? DEN_W'(w_trial - {1'b0, r_den}) : w_trial[DEN_W-1:0];
                    r_num <= {r_num[NUM_W-2:0], w_ge};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    r_head  <= w_hnew;
                    r_quad  <= w_usum[31:30];
                    r_z     <= {{(CW-32){w_d[31]}}, w_d};
                    r_x     <= ddo_pkg::CORDIC_GAIN;
                    r_y     <= '0;
                    r_cnt   <= '0;
                    r_state <= S_COR;
                end
                S_COR: begin
                    r_pr <= w_prod[CW-1:0];
                    if (!r_z[CW-1]) begin
                        r_x <= r_x - w_ys;
                        r_y <= r_y + w_xs;
                        r_z <= r_z - w_at;
                    end else begin
                        r_x <= r_x + w_ys;
                        r_y <= r_y - w_xs;
                        r_z <= r_z + w_at;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(ddo_pkg::CORDIC_STEPS - 1)) begin
                        r_state <= S_CMAP;
                    end
                end
                S_CMAP: begin
                    case (r_quad)
                        2'd0: begin
                            r_c <= r_x;
                            r_s <= r_y;
                        end
                        2'd1: begin
                            r_c <= -r_y;
                            r_s <= r_x;
                        end
                        2'd2: begin
                            r_c <= -r_x;
                            r_s <= -r_y;
                        end
                        default: begin
                            r_c <= r_y;
                            r_s <= -r_x;
                        end
                    endcase
                    r_state <= S_MXL;
                end
                S_MXL: begin
                    r_state <= S_MXH;
                end
                S_MXH: begin
                    r_acc   <= w_pext;
                    r_state <= S_MYL;
                end
                S_MYL: begin
                    r_dx    <= w_sum[ACC_W-1:43];
                    r_state <= S_MYH;
                end
                S_MYH: begin
                    r_acc   <= w_pext;
                    r_state <= S_DY;
                end
                S_DY: begin
                    r_dy    <= w_sum[ACC_W-1:43];
                    r_state <= S_SQ1;
                end
                S_SQ1: begin
                    r_sqn   <= w_prod[SQ_W-1:0];
                    r_state <= S_SQ2;
                end
                S_SQ2: begin
                    r_sqn   <= r_sqn + w_prod[SQ_W-1:0];
                    r_xacc  <= sat_add(r_xacc, r_dx);
                    r_yacc  <= sat_add(r_yacc, r_dy);
                    r_res   <= '0;
                    r_bit   <= SQ_W'(1) << (2 * (SQ_STEPS - 1));
                    r_cnt   <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_sqn >= w_sqt) begin
                        r_sqn <= r_sqn - w_sqt;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(SQ_STEPS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_take) begin
                        r_dist  <= w_dsum[32] ? 32'hFFFF_FFFF : w_dsum[31:0];
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_idle              = (r_state == S_IDLE);
    assign o_done              = (r_state == S_DONE);
    assign o_pose.pos_x        = r_xacc;
    assign o_pose.pos_y        = r_yacc;
    assign o_pose.heading      = w_hw[AB+15:AB];
    assign o_pose.path_length  = w_dsum[32] ? 32'hFFFF_FFFF : w_dsum[31:0];

endmodule
`default_nettype wire
